>>> src/three_level_cache_lookup_macros.svh
// assertion macros shared by the cache lookup rtl
`ifndef THREE_LEVEL_CACHE_LOOKUP_MACROS_SVH
`define THREE_LEVEL_CACHE_LOOKUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLCL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLCL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlcl_pkg.sv
// shared types, codes and helpers for the three level cache lookup
`default_nettype none
package tlcl_pkg;

    localparam int TAG_MAX = 32;

    // hit level codes
    localparam logic [1:0] LVL_L1  = 2'd0;
    localparam logic [1:0] LVL_L2  = 2'd1;
    localparam logic [1:0] LVL_L3  = 2'd2;
    localparam logic [1:0] LVL_MEM = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_COST1  = 3'd1;
    localparam logic [2:0] REG_COST2  = 3'd2;
    localparam logic [2:0] REG_COST3  = 3'd3;
    localparam logic [2:0] REG_COSTM  = 3'd4;

    typedef struct packed {
        logic [TAG_MAX-1:0] tag;
        logic               vld;
        logic               dirty;
        logic [31:0]        age;
        logic [31:0]        uses;
    } line_t;

    typedef struct packed {
        logic clr;
        logic start;
        logic rd;
        logic policy;
    } lvl_ctl_t;

    typedef struct packed {
        logic  hit;
        line_t hit_line;
        line_t vic_line;
    } lvl_res_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

>>> src/tlcl_level.sv
// one cache level: tag store memory with a one-line-per-cycle aging and victim scan
`default_nettype none
module tlcl_level #(
    parameter int LINES = 16,
    parameter int TAG_W = 16,
    parameter int CNT_W = 6,
    localparam int IDX_W = $clog2(LINES)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tlcl_pkg::lvl_ctl_t   ctl,
    input  wire logic [CNT_W-1:0]     cnt,
    input  wire logic [31:0]          tag,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  wire tlcl_pkg::line_t      wr_line,
    output tlcl_pkg::lvl_res_t        res,
    output logic [IDX_W-1:0]          hit_idx,
    output logic [IDX_W-1:0]          vic_idx
);
    import tlcl_pkg::*;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             vld;
        logic             dirty;
        logic [31:0]      age;
        logic [31:0]      uses;
    } ent_t;

    ent_t mem [LINES];
    ent_t rd_data_reg;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    line_t cur;
    line_t aged;
    logic  is_hit;
    logic  best_pick;

    logic             hit_f_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    line_t            hit_line_reg;
    logic             inv_f_reg;
    logic [IDX_W-1:0] inv_idx_reg;
    line_t            inv_line_reg;
    logic [IDX_W-1:0] best_idx_reg;
    line_t            best_line_reg;

    logic             we;
    logic [IDX_W-1:0] wa;
    ent_t             wd;

    assign in_range = {1'b0, cnt} < (CNT_W+1)'(LINES);
    assign idx      = cnt[IDX_W-1:0];

    always_comb
    begin
        cur.tag   = 32'(rd_data_reg.tag);
        cur.vld   = rd_data_reg.vld;
        cur.dirty = rd_data_reg.dirty;
        cur.age   = rd_data_reg.age;
        cur.uses  = rd_data_reg.uses;
        aged      = cur;
        if (cur.vld)
        begin
            aged.age = sat_inc(cur.age);
        end
        is_hit = cur.vld && (cur.tag == tag);
        if (rd_idx_reg == '0)
        begin
            best_pick = 1'b1;
        end
        else if (ctl.policy)
        begin
            best_pick = aged.uses < best_line_reg.uses;
        end
        else
        begin
            best_pick = aged.age > best_line_reg.age;
        end
    end

    // write port: clearing pass, aging write-back, then final update
    always_comb
    begin
        we = 1'b0;
        wa = idx;
        wd = '0;
        if (ctl.clr)
        begin
            we = in_range;
        end
        else if (rd_pend_reg)
        begin
            we       = 1'b1;
            wa       = rd_idx_reg;
            wd.tag   = aged.tag[TAG_W-1:0];
            wd.vld   = aged.vld;
            wd.dirty = aged.dirty;
            wd.age   = aged.age;
            wd.uses  = aged.uses;
        end
        else if (wr_en)
        begin
            we       = 1'b1;
            wa       = wr_idx;
            wd.tag   = wr_line.tag[TAG_W-1:0];
            wd.vld   = wr_line.vld;
            wd.dirty = wr_line.dirty;
            wd.age   = wr_line.age;
            wd.uses  = wr_line.uses;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            hit_f_reg   <= 1'b0;
            inv_f_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ctl.rd && in_range;
            if (ctl.start)
            begin
                hit_f_reg <= 1'b0;
                inv_f_reg <= 1'b0;
            end
            else if (rd_pend_reg)
            begin
                if (is_hit && !hit_f_reg)
                begin
                    hit_f_reg <= 1'b1;
                end
                if (!cur.vld && !inv_f_reg)
                begin
                    inv_f_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx;
        if (rd_pend_reg && !ctl.start)
        begin
            if (is_hit && !hit_f_reg)
            begin
                hit_idx_reg  <= rd_idx_reg;
                hit_line_reg <= aged;
            end
            if (!cur.vld && !inv_f_reg)
            begin
                inv_idx_reg  <= rd_idx_reg;
                inv_line_reg <= aged;
            end
            if (best_pick)
            begin
                best_idx_reg  <= rd_idx_reg;
                best_line_reg <= aged;
            end
        end
    end

    assign res.hit      = hit_f_reg;
    assign res.hit_line = hit_line_reg;
    assign res.vic_line = inv_f_reg ? inv_line_reg : best_line_reg;
    assign hit_idx      = hit_idx_reg;
    assign vic_idx      = inv_f_reg ? inv_idx_reg : best_idx_reg;

endmodule
`default_nettype wire

>>> src/three_level_cache_lookup.sv
// top level: sequencer, register port, level updates, counters and result register
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    mode, block_address
// out       out  out_valid / out_ready  hit_level .. hits_memory
// cfg       in   psel/penable/pready    paddr, pwdata, pwrite, prdata
// an access scans every level one line per cycle through its memory read port, for as
// many lines as the largest level holds, then passes a drain state and an update state
// after reset a clearing pass over every line runs before the first transfer
// the next access is taken while a result waits; the update stalls until it is taken
`default_nettype none
`include "three_level_cache_lookup_macros.svh"
module three_level_cache_lookup #(
    parameter int L1_LINES   = 16,
    parameter int L2_LINES   = 32,
    parameter int L3_LINES   = 64,
    parameter int BLOCK_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [15:0] block_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       hit_level,
    output logic [11:0]      access_cost,
    output logic [39:0]      total_cost,
    output logic             writeback_valid,
    output logic [15:0]      writeback_block,
    output logic [31:0]      hits_l1,
    output logic [31:0]      hits_l2,
    output logic [31:0]      hits_l3,
    output logic [31:0]      hits_memory
);
    import tlcl_pkg::*;

    localparam int MAX12     = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
    localparam int MAX_LINES = (MAX12 > L3_LINES) ? MAX12 : L3_LINES;
    localparam int CNT_W     = $clog2(MAX_LINES);
    localparam int I1_W      = $clog2(L1_LINES);
    localparam int I2_W      = $clog2(L2_LINES);
    localparam int I3_W      = $clog2(L3_LINES);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_cnt;

    logic             policy_reg;
    logic [9:0]       cost1_reg, cost2_reg, cost3_reg, costm_reg;
    logic             cfg_wr;

    logic                  mode_reg;
    logic [BLOCK_BITS-1:0] tag_reg;
    logic [31:0]           addr_ext;

    lvl_ctl_t  ctl;
    lvl_res_t  r1, r2, r3;
    logic [I1_W-1:0] h1_idx, v1_idx, w1_idx;
    logic [I2_W-1:0] h2_idx, v2_idx, w2_idx;
    logic [I3_W-1:0] h3_idx, v3_idx, w3_idx;
    logic  w1_en, w2_en, w3_en;
    line_t w1_line, w2_line, w3_line;
    line_t touched;

    logic        upd_go;
    logic [1:0]  lvl;
    logic [11:0] cost;
    logic        wb;
    logic        casc1, casc2;

    logic        out_valid_reg;
    logic [1:0]  hit_level_reg;
    logic [11:0] access_cost_reg;
    logic [39:0] total_reg;
    logic        wb_valid_reg;
    logic [15:0] wb_block_reg;
    logic [31:0] cnt_l1_reg, cnt_l2_reg, cnt_l3_reg, cnt_mem_reg;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            cost1_reg  <= 10'd1;
            cost2_reg  <= 10'd10;
            cost3_reg  <= 10'd100;
            costm_reg  <= 10'd1000;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_POLICY: policy_reg <= pwdata[0];
                REG_COST1:  cost1_reg  <= pwdata[9:0];
                REG_COST2:  cost2_reg  <= pwdata[9:0];
                REG_COST3:  cost3_reg  <= pwdata[9:0];
                REG_COSTM:  costm_reg  <= pwdata[9:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_POLICY: prdata = {31'd0, policy_reg};
            REG_COST1:  prdata = {22'd0, cost1_reg};
            REG_COST2:  prdata = {22'd0, cost2_reg};
            REG_COST3:  prdata = {22'd0, cost3_reg};
            REG_COSTM:  prdata = {22'd0, costm_reg};
            default:    prdata = '0;
        endcase
    end

    // sequencer
    assign in_ready = (state_reg == ST_IDLE);
    assign last_cnt = (cnt_reg == CNT_W'(MAX_LINES - 1));
    assign upd_go   = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_cnt)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_cnt)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign addr_ext = {16'd0, block_address};

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            tag_reg  <= addr_ext[BLOCK_BITS-1:0];
        end
    end

    assign ctl.clr    = (state_reg == ST_CLR);
    assign ctl.start  = in_valid && in_ready;
    assign ctl.rd     = (state_reg == ST_SCAN);
    assign ctl.policy = policy_reg;

    tlcl_level #(.LINES(L1_LINES), .TAG_W(BLOCK_BITS), .CNT_W(CNT_W)) u_l1 (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .cnt(cnt_reg), .tag(32'(tag_reg)),
        .wr_en(w1_en), .wr_idx(w1_idx), .wr_line(w1_line),
        .res(r1), .hit_idx(h1_idx), .vic_idx(v1_idx)
    );

    tlcl_level #(.LINES(L2_LINES), .TAG_W(BLOCK_BITS), .CNT_W(CNT_W)) u_l2 (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .cnt(cnt_reg), .tag(32'(tag_reg)),
        .wr_en(w2_en), .wr_idx(w2_idx), .wr_line(w2_line),
        .res(r2), .hit_idx(h2_idx), .vic_idx(v2_idx)
    );

    tlcl_level #(.LINES(L3_LINES), .TAG_W(BLOCK_BITS), .CNT_W(CNT_W)) u_l3 (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .cnt(cnt_reg), .tag(32'(tag_reg)),
        .wr_en(w3_en), .wr_idx(w3_idx), .wr_line(w3_line),
        .res(r3), .hit_idx(h3_idx), .vic_idx(v3_idx)
    );

    // line moves for the access outcome; one write per level
    always_comb
    begin
        w1_en   = 1'b0;
        w2_en   = 1'b0;
        w3_en   = 1'b0;
        w1_idx  = v1_idx;
        w2_idx  = v2_idx;
        w3_idx  = v3_idx;
        w1_line = r1.vic_line;
        w2_line = r2.vic_line;
        w3_line = r3.vic_line;
        touched = r1.hit_line;
        lvl     = LVL_MEM;
        wb      = 1'b0;
        casc1   = r1.vic_line.vld && r1.vic_line.dirty;
        casc2   = casc1 && r2.vic_line.vld && r2.vic_line.dirty;
        if (r1.hit)
        begin
            lvl           = LVL_L1;
            touched       = r1.hit_line;
            touched.age   = '0;
            touched.uses  = sat_inc(r1.hit_line.uses);
            touched.dirty = r1.hit_line.dirty | mode_reg;
            w1_en         = upd_go;
            w1_idx        = h1_idx;
            w1_line       = touched;
        end
        else if (r2.hit)
        begin
            lvl           = LVL_L2;
            touched       = r2.hit_line;
            touched.age   = '0;
            touched.uses  = sat_inc(r2.hit_line.uses);
            touched.dirty = r2.hit_line.dirty | mode_reg;
            w1_en         = upd_go;
            w1_line       = touched;
            w2_en         = upd_go;
            w2_idx        = h2_idx;
            w2_line       = r1.vic_line;
        end
        else if (r3.hit)
        begin
            lvl           = LVL_L3;
            touched       = r3.hit_line;
            touched.age   = '0;
            touched.uses  = sat_inc(r3.hit_line.uses);
            touched.dirty = r3.hit_line.dirty | mode_reg;
            w1_en         = upd_go;
            w1_line       = touched;
            w2_en         = upd_go;
            w2_line       = r1.vic_line;
            w3_en         = upd_go;
            w3_idx        = h3_idx;
            w3_line       = r2.vic_line;
        end
        else
        begin
            lvl           = LVL_MEM;
            wb            = casc2 && r3.vic_line.vld && r3.vic_line.dirty;
            w1_en         = upd_go;
            w1_line.tag   = 32'(tag_reg);
            w1_line.vld   = 1'b1;
            w1_line.dirty = mode_reg;
            w1_line.age   = '0;
            w1_line.uses  = 32'd1;
            w2_en         = upd_go && casc1;
            w2_line       = r1.vic_line;
            w2_line.age   = '0;
            w3_en         = upd_go && casc2;
            w3_line       = r2.vic_line;
            w3_line.age   = '0;
        end
    end

    always_comb
    begin
        cost = 12'(cost1_reg);
        if (lvl != LVL_L1)
        begin
            cost = cost + 12'(cost2_reg);
        end
        if (lvl == LVL_L3 || lvl == LVL_MEM)
        begin
            cost = cost + 12'(cost3_reg);
        end
        if (lvl == LVL_MEM)
        begin
            cost = cost + 12'(costm_reg);
        end
    end

    // result register and running counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            cnt_l1_reg    <= '0;
            cnt_l2_reg    <= '0;
            cnt_l3_reg    <= '0;
            cnt_mem_reg   <= '0;
        end
        else if (upd_go)
        begin
            out_valid_reg <= 1'b1;
            total_reg     <= total_reg + 40'(cost);
            case (lvl)
                LVL_L1:  cnt_l1_reg  <= cnt_l1_reg + 32'd1;
                LVL_L2:  cnt_l2_reg  <= cnt_l2_reg + 32'd1;
                LVL_L3:  cnt_l3_reg  <= cnt_l3_reg + 32'd1;
                default: cnt_mem_reg <= cnt_mem_reg + 32'd1;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            hit_level_reg   <= lvl;
            access_cost_reg <= cost;
            wb_valid_reg    <= wb;
            wb_block_reg    <= wb ? r3.vic_line.tag[15:0] : 16'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit_level       = hit_level_reg;
    assign access_cost     = access_cost_reg;
    assign total_cost      = total_reg;
    assign writeback_valid = wb_valid_reg;
    assign writeback_block = wb_block_reg;
    assign hits_l1         = cnt_l1_reg;
    assign hits_l2         = cnt_l2_reg;
    assign hits_l3         = cnt_l3_reg;
    assign hits_memory     = cnt_mem_reg;

    `TLCL_ASSERT_IMP(a_wb_only_on_miss, out_valid && writeback_valid, hit_level == LVL_MEM, "write-back without a miss")
    `TLCL_ASSERT_NXT(a_accept_starts_scan, in_valid && in_ready, state_reg == ST_SCAN, "transfer did not start a scan")
    `TLCL_ASSERT_IMP(a_no_accept_in_clear, state_reg == ST_CLR, !in_ready, "ready during clearing pass")

endmodule
`default_nettype wire
